// ===== rtl/quadratic_interp_resampler_defines.svh =====
// Assertion macros for the quadratic interpolating resampler.
// Included by the top level; the macros expect i_clk and i_rst_n in scope.
`ifndef QUADRATIC_INTERP_RESAMPLER_DEFINES_SVH
`define QUADRATIC_INTERP_RESAMPLER_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define QIR_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("qir: same-cycle check failed");
// next-cycle implication
`define QIR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("qir: next-cycle check failed");
`else
`define QIR_ASSERT_IMPLY(label, ante, cons)
`define QIR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/qir_pkg.sv =====
// Shared constants, types and helpers of the quadratic interpolating resampler.
// No dependencies; imported by every module of the block.
package qir_pkg;

    // block dimensions
    localparam int MAX_CHANNELS   = 4;
    localparam int LANES          = 4;
    localparam int STEP_FRAC_BITS = 16;
    localparam int WINDOW_FRAMES  = 3;
    localparam int SAMPLE_W       = 16;
    localparam int STEP_W         = 19;
    localparam int CHANS_W        = 3;
    localparam int CHAN_W         = 2;
    localparam int LANE_AW        = $clog2(LANES);
    localparam int HIST_W         = SAMPLE_W * WINDOW_FRAMES;
    localparam int POS_W          = STEP_FRAC_BITS + 4;
    localparam int X_FRAC         = 16;
    localparam int X_W            = X_FRAC + 1;
    localparam int RESULT_LIMIT   = 64;
    localparam int COUNT_W        = $clog2(RESULT_LIMIT + 1);
    localparam int CHAN_LIMIT     = (MAX_CHANNELS < LANES) ? MAX_CHANNELS : LANES;

    // position to Q16 interpolation abscissa
    localparam int X_SHR = (STEP_FRAC_BITS > X_FRAC) ? STEP_FRAC_BITS - X_FRAC : 0;
    localparam int X_SHL = (STEP_FRAC_BITS < X_FRAC) ? X_FRAC - STEP_FRAC_BITS : 0;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANS = 1'd1;

    localparam logic [STEP_W-1:0]  STEP_RESET  = STEP_W'(65536);
    localparam logic [CHANS_W-1:0] CHANS_RESET = CHANS_W'(2);
    localparam logic [STEP_W-1:0]  MIN_STEP    = STEP_W'(1) << (STEP_FRAC_BITS - 3);
    localparam logic [POS_W-1:0]   POS_ONE     = POS_W'(1) << STEP_FRAC_BITS;
    localparam logic [POS_W-1:0]   POS_TWO     = POS_W'(2) << STEP_FRAC_BITS;

    // output clamp
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFE;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sh7FFF;

    // history memory port
    typedef struct packed {
        logic                rd_en;
        logic [LANE_AW-1:0]  rd_addr;
        logic                wr_en;
        logic [LANE_AW-1:0]  wr_addr;
        logic [HIST_W-1:0]   wr_data;
    } t_mem_req;

    // one interpolation job
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] y0;
        logic signed [SAMPLE_W-1:0] y1;
        logic signed [SAMPLE_W-1:0] y2;
        logic [X_W-1:0]             x;
    } t_interp_req;

    // position (below two frames) to Q16 abscissa
    function automatic logic [X_W-1:0] to_x(input logic [POS_W-1:0] pos);
        logic [POS_W+X_FRAC-1:0] t;
        t = ((POS_W + X_FRAC)'(pos) >> X_SHR) << X_SHL;
        return t[X_W-1:0];
    endfunction

endpackage

// ===== rtl/qir_hist_mem.sv =====
// Per-lane sample history: one entry per channel holding the three window frames.
// Synchronous memory, one read and one write a cycle; depends on qir_pkg.
module qir_hist_mem (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  qir_pkg::t_mem_req            i_req,
    output logic [qir_pkg::HIST_W-1:0]   o_rd_data
);
    import qir_pkg::*;

    logic [HIST_W-1:0] r_mem [LANES];
    logic [HIST_W-1:0] r_rd_data;
    logic [LANES-1:0]  r_valid;
    logic              r_rd_valid;

    // storage and registered read
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    // entries read as zero until first written after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_valid <= r_valid[i_req.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

// ===== rtl/qir_interp.sv =====
// Three-stage quadratic evaluation: y0 + B*x/2 + A*x*x/2, truncated and clamped.
// Horner form, one multiplier each for A*x and for (B*2^16 + A*x) * x; depends on qir_pkg.
module qir_interp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_req_valid,
    input  qir_pkg::t_interp_req                 i_req,
    output logic                                 o_res_valid,
    output logic signed [qir_pkg::SAMPLE_W-1:0]  o_res
);
    import qir_pkg::*;

    localparam int A_W  = SAMPLE_W + 2;
    localparam int B_W  = SAMPLE_W + 4;
    localparam int XS_W = X_W + 1;
    localparam int AX_W = A_W + XS_W;
    localparam int U_W  = AX_W + 1;
    localparam int W_W  = U_W + XS_W;
    localparam int N_W  = W_W + 1;
    localparam int SH   = 2 * X_FRAC + 1;
    localparam int V_W  = N_W - SH;
    localparam logic signed [V_W-1:0] V_MAX = V_W'(SAMPLE_MAX);
    localparam logic signed [V_W-1:0] V_MIN = V_W'(SAMPLE_MIN);

    logic signed [A_W-1:0]      a;
    logic signed [B_W-1:0]      b;
    logic signed [XS_W-1:0]     xs;
    logic signed [AX_W-1:0]     ax;
    logic signed [B_W-1:0]      r_b;
    logic signed [AX_W-1:0]     r_ax;
    logic signed [XS_W-1:0]     r_xs;
    logic signed [SAMPLE_W-1:0] r_y0_1;
    logic signed [SAMPLE_W-1:0] r_y0_2;
    logic signed [U_W-1:0]      u;
    logic signed [W_W-1:0]      w;
    logic signed [W_W-1:0]      r_w;
    logic signed [N_W-1:0]      n;
    logic signed [V_W-1:0]      q;
    logic signed [V_W-1:0]      v;
    logic                       rnd;
    logic                       r_v1;
    logic                       r_v2;
    logic                       r_v3;
    logic signed [SAMPLE_W-1:0] r_res;

    // stage 1: coefficients and A*x
    assign a  = A_W'(i_req.y0) - (A_W'(i_req.y1) <<< 1) + A_W'(i_req.y2);
    assign b  = (B_W'(i_req.y1) <<< 2) - B_W'(i_req.y0) - (B_W'(i_req.y0) <<< 1)
              - B_W'(i_req.y2);
    assign xs = signed'({1'b0, i_req.x});
    assign ax = AX_W'(a) * AX_W'(xs);

    // stage 2: (B*2^16 + A*x) * x
    assign u = (U_W'(r_b) <<< X_FRAC) + U_W'(r_ax);
    assign w = W_W'(u) * W_W'(r_xs);

    // stage 3: add y0*2^33, divide by 2^33 toward zero, clamp
    assign n   = (N_W'(r_y0_2) <<< SH) + N_W'(r_w);
    assign q   = n[N_W-1:SH];
    assign rnd = n[N_W-1] && (|n[SH-1:0]);
    assign v   = q + signed'({{(V_W-1){1'b0}}, rnd});

    always_ff @(posedge i_clk) begin
        r_b    <= b;
        r_ax   <= ax;
        r_xs   <= xs;
        r_y0_1 <= i_req.y0;
        r_w    <= w;
        r_y0_2 <= r_y0_1;
        if (r_v2) begin
            if (v > V_MAX) begin
                r_res <= SAMPLE_MAX;
            end else if (v < V_MIN) begin
                r_res <= SAMPLE_MIN;
            end else begin
                r_res <= SAMPLE_W'(v);
            end
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_req_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_res_valid = r_v3;
    assign o_res       = r_res;

endmodule

// ===== rtl/quadratic_interp_resampler.sv =====
// Quadratic interpolating resampler. One frame of up to four 16-bit channels is
// taken per input item; from the third frame on, each frame yields the output
// positions below two frames of the window (at most 64 results), channel by channel,
// as signed 16-bit items tagged with their channel, tlast on the frame's final one.
// Each frame is first shifted into the per-channel history memory (one lane a
// cycle, read then write back), then the position is updated, and the window is
// checked once per output position plus once to close the frame. Each result
// then needs a history read, the three-stage multiply pipeline, which is shared
// by all results, and a load of the output register, held while that register is
// full and tready is low. No reset sweep is needed: history entries read as zero
// until written. Configuration is taken at any time and applies from the next frame.
`include "quadratic_interp_resampler_defines.svh"

module quadratic_interp_resampler (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_s_axis_tvalid,
    output logic                                            o_s_axis_tready,
    // sample_0 [15:0], sample_1 [31:16], sample_2 [47:32], sample_3 [63:48]
    input  logic [qir_pkg::LANES*qir_pkg::SAMPLE_W-1:0]     i_s_axis_tdata,
    output logic                                            o_m_axis_tvalid,
    input  logic                                            i_m_axis_tready,
    // out_sample [15:0]
    output logic signed [qir_pkg::SAMPLE_W-1:0]             o_m_axis_tdata,
    // out_channel [1:0]
    output logic [qir_pkg::CHAN_W-1:0]                      o_m_axis_tuser,
    output logic                                            o_m_axis_tlast,
    input  logic                                            i_cfg_valid,
    output logic                                            o_cfg_ready,
    input  logic [qir_pkg::CFG_IDX_W-1:0]                   i_cfg_index,
    input  logic [qir_pkg::STEP_W-1:0]                      i_cfg_data
);
    import qir_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SHIFT  = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_POS    = 3'd3;
    localparam logic [2:0] S_RD     = 3'd4;
    localparam logic [2:0] S_MEM    = 3'd5;
    localparam logic [2:0] S_CALC   = 3'd6;
    localparam logic [2:0] S_OUT    = 3'd7;

    localparam logic [1:0]         FS_FULL  = 2'd3;
    localparam logic [LANE_AW:0]   LANE_END = (LANE_AW + 1)'(LANES);
    localparam logic [COUNT_W:0]   LIMIT_V  = (COUNT_W + 1)'(RESULT_LIMIT);
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(RESULT_LIMIT);

    logic [2:0]              r_state;
    logic [2:0]              n_state;
    logic [STEP_W-1:0]       r_step_cfg;
    logic [CHANS_W-1:0]      r_chans_cfg;
    logic [STEP_W-1:0]       r_step;
    logic [CHANS_W-1:0]      r_chans;
    logic [SAMPLE_W-1:0]     r_frame [LANES];
    logic [LANE_AW:0]        r_lane;
    logic [CHAN_W-1:0]       r_chan;
    logic [POS_W-1:0]        r_pos;
    logic [1:0]              r_fs;
    logic [COUNT_W-1:0]      r_count;
    logic                    r_last;
    logic                    r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_data;
    logic [CHAN_W-1:0]       r_out_chan;
    logic                    r_out_last;

    logic                    in_acc;
    logic [STEP_W-1:0]       step_eff;
    logic [CHANS_W-1:0]      chans_eff;
    logic [POS_W-1:0]        pos_next;
    logic                    chan_end;
    logic                    grp_ok;
    logic                    next_ok;
    logic                    last_c;
    logic                    out_load;
    logic [LANE_AW-1:0]      wr_lane;
    t_mem_req                mem_req;
    logic [HIST_W-1:0]       mem_rd_data;
    t_interp_req             ip_req;
    logic                    ip_req_valid;
    logic                    ip_res_valid;
    logic signed [SAMPLE_W-1:0] ip_res;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    // register values as used for one frame
    assign step_eff = (r_step_cfg < MIN_STEP) ? MIN_STEP : r_step_cfg;
    always_comb begin
        if (r_chans_cfg == '0) begin
            chans_eff = CHANS_W'(1);
        end else if (r_chans_cfg > CHANS_W'(CHAN_LIMIT)) begin
            chans_eff = CHANS_W'(CHAN_LIMIT);
        end else begin
            chans_eff = r_chans_cfg;
        end
    end

    // position and result-count bookkeeping
    assign pos_next = r_pos + POS_W'(r_step);
    assign chan_end = (CHANS_W'(r_chan) == r_chans - CHANS_W'(1));
    assign grp_ok   = ((COUNT_W + 1)'(r_count) + (COUNT_W + 1)'(r_chans)) <= LIMIT_V;
    assign next_ok  = (pos_next < POS_TWO) &&
                      (((COUNT_W + 1)'(r_count) + (COUNT_W + 1)'(1)
                        + (COUNT_W + 1)'(r_chans)) <= LIMIT_V);
    assign last_c   = chan_end && !next_ok;
    assign out_load = (r_state == S_OUT) && (!r_out_valid || i_m_axis_tready);

    // history port: lane shift is read lane k while writing back lane k-1
    assign wr_lane = LANE_AW'(r_lane - (LANE_AW + 1)'(1));
    always_comb begin
        mem_req = '0;
        if (r_state == S_SHIFT) begin
            mem_req.rd_en   = (r_lane != LANE_END);
            mem_req.rd_addr = r_lane[LANE_AW-1:0];
            mem_req.wr_en   = (r_lane != '0);
            mem_req.wr_addr = wr_lane;
            mem_req.wr_data = {r_frame[wr_lane], mem_rd_data[HIST_W-1:SAMPLE_W]};
        end else if (r_state == S_RD) begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = LANE_AW'(r_chan);
        end
    end

    qir_hist_mem u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_rd_data (mem_rd_data)
    );

    // interpolation job from the lane just read
    assign ip_req_valid = (r_state == S_MEM);
    assign ip_req.y0 = signed'(mem_rd_data[SAMPLE_W-1:0]);
    assign ip_req.y1 = signed'(mem_rd_data[2*SAMPLE_W-1:SAMPLE_W]);
    assign ip_req.y2 = signed'(mem_rd_data[3*SAMPLE_W-1:2*SAMPLE_W]);
    assign ip_req.x  = to_x(r_pos);

    qir_interp u_interp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (ip_req_valid),
        .i_req       (ip_req),
        .o_res_valid (ip_res_valid),
        .o_res       (ip_res)
    );

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (in_acc) n_state = S_SHIFT;
            S_SHIFT:  if (r_lane == LANE_END) n_state = S_DECIDE;
            S_DECIDE: n_state = (r_fs < 2'd2) ? S_IDLE : S_POS;
            S_POS:    n_state = ((r_pos < POS_TWO) && grp_ok) ? S_RD : S_IDLE;
            S_RD:     n_state = S_MEM;
            S_MEM:    n_state = S_CALC;
            S_CALC:   if (ip_res_valid) n_state = S_OUT;
            S_OUT:    if (out_load) n_state = chan_end ? S_POS : S_RD;
            default:  n_state = S_IDLE;
        endcase
    end

    // sequencer and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step_cfg  <= STEP_RESET;
            r_chans_cfg <= CHANS_RESET;
            r_step      <= STEP_RESET;
            r_chans     <= CHANS_RESET;
            r_lane      <= '0;
            r_chan      <= '0;
            r_pos       <= '0;
            r_fs        <= '0;
            r_count     <= '0;
            r_last      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_STEP:  r_step_cfg  <= i_cfg_data;
                    REG_CHANS: r_chans_cfg <= i_cfg_data[CHANS_W-1:0];
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_step  <= step_eff;
                        r_chans <= chans_eff;
                        r_lane  <= '0;
                        r_count <= '0;
                    end
                end
                S_SHIFT: r_lane <= r_lane + (LANE_AW + 1)'(1);
                S_DECIDE: begin
                    // window filling, then one frame back per frame
                    if (r_fs < 2'd2) begin
                        r_fs <= r_fs + 2'd1;
                    end else if (r_fs == FS_FULL) begin
                        if (r_pos >= POS_ONE) begin
                            r_pos <= r_pos - POS_ONE;
                        end
                    end else begin
                        r_fs <= FS_FULL;
                    end
                end
                S_POS: r_chan <= '0;
                S_RD:  r_last <= last_c;
                S_OUT: begin
                    if (out_load) begin
                        r_count <= r_count + COUNT_W'(1);
                        if (chan_end) begin
                            r_pos <= pos_next;
                        end else begin
                            r_chan <= r_chan + CHAN_W'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // frame capture
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            for (int l = 0; l < LANES; l++) begin
                r_frame[l] <= i_s_axis_tdata[l*SAMPLE_W +: SAMPLE_W];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= ip_res;
            r_out_chan <= r_chan;
            r_out_last <= r_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_chan;
    assign o_m_axis_tlast  = r_out_last;

    // checks
    `QIR_ASSERT_IMPLY(a_count_bound, 1'b1, r_count <= COUNT_MAX)
    `QIR_ASSERT_IMPLY(a_rd_in_window, r_state == S_RD, r_pos < POS_TWO)
    `QIR_ASSERT_IMPLY(a_no_rmw_clash, mem_req.rd_en && mem_req.wr_en, mem_req.rd_addr != mem_req.wr_addr)
    `QIR_ASSERT_NEXT(a_last_ends_run, out_load && r_last, r_state == S_POS && !(r_pos < POS_TWO && grp_ok))

endmodule
